/* rtl/int_list_table_engine_assert.svh */
// assertion macros shared by the list table engine modules
`ifndef INT_LIST_TABLE_ENGINE_ASSERT_SVH
`define INT_LIST_TABLE_ENGINE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ILTE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication, checked outside reset
`define ILTE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

/* rtl/ilte_pkg.sv */
// shared constants and types of the list table engine
`timescale 1ns / 1ps
package ilte_pkg;

   localparam int CAPACITY_DEF = 128;
   localparam int VALUE_W      = 32;
   localparam int KIND_W       = 2;
   localparam int STATUS_W     = 2;
   localparam int POS_W        = 7;
   localparam int CNT_OUT_W    = 8;

   localparam logic [KIND_W-1:0] KIND_APPEND  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_MARK    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_COMPACT = 2'd2;
   localparam logic [KIND_W-1:0] KIND_SEARCH  = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd3;

   localparam logic [VALUE_W-1:0] MARKER = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [VALUE_W-1:0] value;
   } cmd_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [POS_W-1:0]     position;
      logic [CNT_OUT_W-1:0] count;
   } res_type;

   typedef struct packed {
      logic idle;
      logic res_vld;
   } stat_type;

endpackage

/* rtl/ilte_if.sv */
// request and response channel interfaces
`timescale 1ns / 1ps
interface ilte_req_if;
   import ilte_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [KIND_W-1:0]         req_type;
   logic signed [VALUE_W-1:0] value;
   modport source (output valid, req_type, value, input ready);
   modport sink (input valid, req_type, value, output ready);
endinterface

interface ilte_rsp_if;
   import ilte_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [POS_W-1:0]     position;
   logic [CNT_OUT_W-1:0] count;
   modport source (output valid, status, position, count, input ready);
   modport sink (input valid, status, position, count, output ready);
endinterface

/* rtl/int_list_table_engine.sv */
// list table engine top level: request intake, sequencer and response register
// zero value, append, empty-list requests: result via sequencer and response registers
// remove and search walk the ram one entry a cycle
// one request at a time: next beat taken when idle and the response slot can take it
// synchronous reset empties the list; ram contents are not cleared
`timescale 1ns / 1ps
module int_list_table_engine #(
   parameter int CAPACITY = ilte_pkg::CAPACITY_DEF
) (
   input logic       clock,
   input logic       reset,
   ilte_req_if.sink  req_bus,
   ilte_rsp_if.source rsp_bus
);
   import ilte_pkg::*;

   logic     req_fire;
   logic     rsp_fire;
   cmd_type  cmd;
   stat_type stat;
   res_type  res;
   logic     rsp_valid_ff, rsp_valid_in;
   res_type  rsp_ff, rsp_in;

   assign cmd.kind  = req_bus.req_type;
   assign cmd.value = req_bus.value;

   // a new request only when the response slot is free by the time its result lands
   assign req_bus.ready = stat.idle && (!rsp_valid_ff || rsp_bus.ready);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign rsp_fire      = rsp_valid_ff && rsp_bus.ready;

   ilte_scan #(.CAPACITY(CAPACITY)) u_scan (
      .clock (clock),
      .reset (reset),
      .start (req_fire),
      .cmd   (cmd),
      .stat  (stat),
      .res   (res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (stat.res_vld) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.status   = rsp_ff.status;
   assign rsp_bus.position = rsp_ff.position;
   assign rsp_bus.count    = rsp_ff.count;

`include "int_list_table_engine_assert.svh"

   `ILTE_ASSERT_IMPLY(a_slot_free, clock, reset, stat.res_vld, !rsp_valid_ff)
   `ILTE_ASSERT_NEXT(a_one_in_flight, clock, reset, req_fire, !req_bus.ready)
   `ILTE_ASSERT_NEXT(a_rsp_drained, clock, reset, rsp_fire, !rsp_valid_ff)

endmodule

/* rtl/ilte_ram.sv */
// generic single-write single-read ram with registered read data
`timescale 1ns / 1ps
module ilte_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* rtl/ilte_scan.sv */
// request sequencer: append, walk the list for remove and search, keep the fill count
`timescale 1ns / 1ps
module ilte_scan #(
   parameter int CAPACITY = ilte_pkg::CAPACITY_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  ilte_pkg::cmd_type  cmd,
   output ilte_pkg::stat_type stat,
   output ilte_pkg::res_type  res
);
   import ilte_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   logic               busy_ff, busy_in;
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [AW-1:0]      cur_ff, cur_in;
   logic [CW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic               hit_ff, hit_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               res_vld_ff, res_vld_in;
   res_type            res_ff, res_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [VALUE_W-1:0] wr_data;
   logic [AW-1:0]      rd_addr;
   logic [VALUE_W-1:0] rd_data;
   logic               match;
   logic               last;
   logic               done;

   ilte_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // read data belongs to the entry at cur_ff
   assign match = (rd_data == value_ff);
   assign last  = ((CW'(cur_ff) + CW'(1)) == count_ff);

   always_comb begin
      busy_in    = busy_ff;
      kind_in    = kind_ff;
      value_in   = value_ff;
      cur_in     = cur_ff;
      wr_ptr_in  = wr_ptr_ff;
      hit_in     = hit_ff;
      count_in   = count_ff;
      res_vld_in = 1'b0;
      res_in     = res_ff;
      wr_en      = 1'b0;
      wr_addr    = count_ff[AW-1:0];
      wr_data    = cmd.value;
      rd_addr    = '0;
      done       = 1'b0;

      if (start) begin
         kind_in   = cmd.kind;
         value_in  = cmd.value;
         cur_in    = '0;
         wr_ptr_in = '0;
         hit_in    = 1'b0;
         res_in.position = '0;
         if (cmd.value == '0) begin
            res_in.status = ST_INVALID;
            res_vld_in    = 1'b1;
         end else if (cmd.kind == KIND_APPEND) begin
            res_vld_in = 1'b1;
            if (count_ff == CW'(CAPACITY)) begin
               res_in.status = ST_FULL;
            end else begin
               wr_en           = 1'b1;
               count_in        = count_ff + CW'(1);
               res_in.status   = ST_OK;
               res_in.position = POS_W'(count_ff);
            end
         end else if (count_ff == '0) begin
            res_in.status = ST_NOT_FOUND;
            res_vld_in    = 1'b1;
         end else begin
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         // read one entry ahead; writes only land at or below cur_ff
         cur_in  = cur_ff + AW'(1);
         rd_addr = cur_in;
         case (kind_ff)
            KIND_MARK: begin
               if (match) begin
                  wr_en   = 1'b1;
                  wr_addr = cur_ff;
                  wr_data = MARKER;
                  hit_in  = 1'b1;
               end
               done = last;
            end
            KIND_COMPACT: begin
               if (match) begin
                  hit_in = 1'b1;
               end else begin
                  wr_en     = 1'b1;
                  wr_addr   = wr_ptr_ff[AW-1:0];
                  wr_data   = rd_data;
                  wr_ptr_in = wr_ptr_ff + CW'(1);
               end
               done = last;
               if (last) begin
                  count_in = wr_ptr_in;
               end
            end
            default: begin
               hit_in = match;
               done   = match || last;
            end
         endcase
         if (done) begin
            busy_in         = 1'b0;
            res_vld_in      = 1'b1;
            res_in.status   = hit_in ? ST_OK : ST_NOT_FOUND;
            res_in.position = (kind_ff == KIND_SEARCH && match) ? POS_W'(cur_ff) : '0;
         end
      end
      res_in.count = CNT_OUT_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         count_ff   <= '0;
         res_vld_ff <= 1'b0;
      end else begin
         busy_ff    <= busy_in;
         count_ff   <= count_in;
         res_vld_ff <= res_vld_in;
      end
      kind_ff   <= kind_in;
      value_ff  <= value_in;
      cur_ff    <= cur_in;
      wr_ptr_ff <= wr_ptr_in;
      hit_ff    <= hit_in;
      res_ff    <= res_in;
   end

   assign stat.idle    = !busy_ff && !res_vld_ff;
   assign stat.res_vld = res_vld_ff;
   assign res          = res_ff;

`include "int_list_table_engine_assert.svh"

   `ILTE_ASSERT_IMPLY(a_start_idle, clock, reset, start, !busy_ff && !res_vld_ff)
   `ILTE_ASSERT_NEXT(a_res_single, clock, reset, res_vld_ff, !res_vld_ff)
   `ILTE_ASSERT_IMPLY(a_walk_bound, clock, reset, busy_ff, (CW'(cur_ff) < count_ff))
   `ILTE_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, (count_ff <= CW'(CAPACITY)))

endmodule

/* tb/sv/int_list_table_engine_tb.sv */
// testbench for the list table engine: directed table, random requests, response scoreboard
`timescale 1ns / 1ps
module int_list_table_engine_tb;
   import ilte_pkg::*;

   localparam int CAP        = CAPACITY_DEF;
   localparam int RAND_BEATS = 800;
   localparam int LIMIT      = 1500000;
   localparam int N_DIR      = 24;

   typedef struct packed {
      logic [KIND_W-1:0]    kind;
      logic [VALUE_W-1:0]   value;
      logic                 typed;
      logic [STATUS_W-1:0]  status;
      logic [POS_W-1:0]     position;
      logic [CNT_OUT_W-1:0] count;
   } dir_row_type;

   // typed rows carry their own result, the rest go through the list model
   localparam dir_row_type DIR_ROWS [N_DIR] = '{
      '{KIND_SEARCH,  32'd5,          1'b1, ST_NOT_FOUND, 7'd0, 8'd0},
      '{KIND_MARK,    32'd5,          1'b1, ST_NOT_FOUND, 7'd0, 8'd0},
      '{KIND_COMPACT, 32'd5,          1'b1, ST_NOT_FOUND, 7'd0, 8'd0},
      '{KIND_APPEND,  32'd0,          1'b1, ST_INVALID,   7'd0, 8'd0},
      '{KIND_MARK,    32'd0,          1'b1, ST_INVALID,   7'd0, 8'd0},
      '{KIND_COMPACT, 32'd0,          1'b1, ST_INVALID,   7'd0, 8'd0},
      '{KIND_SEARCH,  32'd0,          1'b1, ST_INVALID,   7'd0, 8'd0},
      '{KIND_APPEND,  32'h7FFF_FFFF,  1'b1, ST_OK,        7'd0, 8'd1},
      '{KIND_APPEND,  32'h8000_0000,  1'b1, ST_OK,        7'd1, 8'd2},
      '{KIND_APPEND,  MARKER,         1'b1, ST_OK,        7'd2, 8'd3},
      '{KIND_APPEND,  32'd1,          1'b1, ST_OK,        7'd3, 8'd4},
      '{KIND_APPEND,  32'd7,          1'b0, ST_OK,        7'd0, 8'd0},
      '{KIND_APPEND,  32'd7,          1'b0, ST_OK,        7'd0, 8'd0},
      '{KIND_SEARCH,  32'd7,          1'b0, ST_OK,        7'd0, 8'd0},
      '{KIND_MARK,    32'd7,          1'b0, ST_OK,        7'd0, 8'd0},
      '{KIND_SEARCH,  MARKER,         1'b0, ST_OK,        7'd0, 8'd0},
      '{KIND_COMPACT, MARKER,         1'b0, ST_OK,        7'd0, 8'd0},
      '{KIND_SEARCH,  32'h8000_0000,  1'b0, ST_OK,        7'd0, 8'd0},
      '{KIND_MARK,    MARKER,         1'b0, ST_OK,        7'd0, 8'd0},
      '{KIND_APPEND,  MARKER,         1'b0, ST_OK,        7'd0, 8'd0},
      '{KIND_MARK,    MARKER,         1'b0, ST_OK,        7'd0, 8'd0},
      '{KIND_COMPACT, 32'h7FFF_FFFF,  1'b0, ST_OK,        7'd0, 8'd0},
      '{KIND_SEARCH,  32'd1,          1'b0, ST_OK,        7'd0, 8'd0},
      '{KIND_COMPACT, 32'd1,          1'b0, ST_OK,        7'd0, 8'd0}
   };

   logic clock = 1'b0;
   logic reset;

   ilte_req_if req_bus ();
   ilte_rsp_if rsp_bus ();

   int_list_table_engine dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #5 clock = ~clock;

   // list model state
   logic [VALUE_W-1:0] list_mem [CAP];
   int                 list_fill;

   res_type            pending_rsp [$];
   logic [VALUE_W-1:0] value_pool [16];
   int                 errors;
   int                 beats_sent;
   int                 cycles;
   bit                 calm_tx;
   bit                 calm_rx;

   function automatic res_type list_apply(input logic [KIND_W-1:0] kind,
                                          input logic [VALUE_W-1:0] val);
      res_type r;
      int      i;
      int      w;
      bit      hit;
      r = '0;
      hit = 1'b0;
      if (val == '0) begin
         r.status = ST_INVALID;
      end else begin
         case (kind)
            KIND_APPEND: begin
               if (list_fill >= CAP) begin
                  r.status = ST_FULL;
               end else begin
                  list_mem[list_fill] = val;
                  r.position = list_fill[POS_W-1:0];
                  list_fill++;
                  r.status = ST_OK;
               end
            end
            KIND_MARK: begin
               for (i = 0; i < list_fill; i++) begin
                  if (list_mem[i] == val) begin
                     list_mem[i] = MARKER;
                     hit = 1'b1;
                  end
               end
               r.status = hit ? ST_OK : ST_NOT_FOUND;
            end
            KIND_COMPACT: begin
               w = 0;
               for (i = 0; i < list_fill; i++) begin
                  if (list_mem[i] == val) begin
                     hit = 1'b1;
                  end else begin
                     list_mem[w] = list_mem[i];
                     w++;
                  end
               end
               list_fill = w;
               r.status = hit ? ST_OK : ST_NOT_FOUND;
            end
            default: begin
               r.status = ST_NOT_FOUND;
               for (i = 0; i < list_fill && !hit; i++) begin
                  if (list_mem[i] == val) begin
                     hit = 1'b1;
                     r.status = ST_OK;
                     r.position = i[POS_W-1:0];
                  end
               end
            end
         endcase
      end
      r.count = list_fill[CNT_OUT_W-1:0];
      return r;
   endfunction

   // mostly back to back, some short gaps, a few long ones; always back to back when calm
   function automatic int pick_gap(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value(input bit nonzero);
      int r;
      r = $urandom_range(0, 99);
      if (r < 5 && !nonzero) return '0;
      if (r < 30) return $urandom | (nonzero ? 32'd1 : 32'd0);
      return value_pool[$urandom_range(0, 15)];
   endfunction

   task automatic push_req(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] val,
                           input bit typed, input res_type fixed);
      int      gap;
      res_type pred;
      if ($urandom_range(0, 49) == 0) calm_tx = !calm_tx;
      gap = pick_gap(calm_tx);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.req_type <= kind;
      req_bus.value    <= val;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pred = list_apply(kind, val);
      pending_rsp.push_back(typed ? fixed : pred);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic drain_rsp();
      req_bus.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
   endtask

   // append until the list is full, push past it, then search for the value last appended here (zero if none)
   task automatic fill_to_top();
      logic [VALUE_W-1:0] last;
      last = '0;
      while (list_fill < CAP) begin
         last = pick_value(1'b1);
         push_req(KIND_APPEND, last, 1'b0, '0);
      end
      repeat (3) push_req(KIND_APPEND, pick_value(1'b1), 1'b0, '0);
      push_req(KIND_SEARCH, last, 1'b0, '0);
   endtask

   task automatic random_req();
      int                 r;
      logic [KIND_W-1:0]  kind;
      logic [VALUE_W-1:0] val;
      r = $urandom_range(0, 99);
      if (r < 40) kind = KIND_APPEND;
      else if (r < 55) kind = KIND_MARK;
      else if (r < 65) kind = KIND_COMPACT;
      else kind = KIND_SEARCH;
      val = pick_value(1'b0);
      // aim removes and searches at a stored entry 40 percent of the time
      if (kind != KIND_APPEND && list_fill > 0 && $urandom_range(0, 99) < 40)
         val = list_mem[$urandom_range(0, list_fill - 1)];
      push_req(kind, val, 1'b0, '0);
   endtask

   initial begin
      int      k;
      res_type fixed;
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.req_type <= KIND_APPEND;
      req_bus.value    <= '0;
      errors     = 0;
      beats_sent = 0;
      list_fill  = 0;
      calm_tx    = 1'b0;
      value_pool[0] = MARKER;
      value_pool[1] = 32'h8000_0000;
      value_pool[2] = 32'h7FFF_FFFF;
      value_pool[3] = 32'd1;
      for (k = 4; k < 16; k++) value_pool[k] = $urandom | 32'd1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (k = 0; k < N_DIR; k++) begin
         fixed.status   = DIR_ROWS[k].status;
         fixed.position = DIR_ROWS[k].position;
         fixed.count    = DIR_ROWS[k].count;
         push_req(DIR_ROWS[k].kind, DIR_ROWS[k].value, DIR_ROWS[k].typed, fixed);
      end
      drain_rsp();

      fill_to_top();
      while (beats_sent < N_DIR + RAND_BEATS) begin
         if (beats_sent == N_DIR + RAND_BEATS / 2) drain_rsp();
         if ($urandom_range(0, 99) == 0) fill_to_top();
         else random_req();
      end

      drain_rsp();
      repeat (140) @(posedge clock);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // response side back pressure, with calm stretches
   initial begin
      int stall_left;
      stall_left = 0;
      calm_rx = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 199) == 0) calm_rx = !calm_rx;
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            stall_left = pick_gap(calm_rx);
         end
      end
   end

   always @(posedge clock) begin
      res_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected beat: status %0d position %0d count %0d", $time,
                     rsp_bus.status, rsp_bus.position, rsp_bus.count);
            errors++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_bus.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_bus.status);
               errors++;
            end
            if (rsp_bus.position !== want.position) begin
               $display("%0t: position expected %0d actual %0d", $time, want.position,
                        rsp_bus.position);
               errors++;
            end
            if (rsp_bus.count !== want.count) begin
               $display("%0t: count expected %0d actual %0d", $time, want.count,
                        rsp_bus.count);
               errors++;
            end
         end
      end
   end

   initial cycles = 0;

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("%0t: timeout with %0d responses outstanding", $time, pending_rsp.size());
         $display("Some tests failed");
         $finish;
      end
   end

endmodule

/* int_list_table_engine.f */
+incdir+rtl
rtl/ilte_pkg.sv
rtl/ilte_if.sv
rtl/ilte_ram.sv
rtl/ilte_scan.sv
rtl/int_list_table_engine.sv
tb/sv/int_list_table_engine_tb.sv
